### hw/rtl/sha256_message_digest_defines.svh
// Assertion macros for the SHA-256 digest block
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sha256 check failed");
`define SHA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sha256 check failed");
`else
`define SHA_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SHA_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/sha_pkg.sv
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       last;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        error;
        logic        last_word;
    } sha_out_t;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [8:0] PAD_FILL  = 9'd448;

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

### hw/rtl/sha_round.sv
// One SHA-256 round plus message schedule step, reused for all 64 rounds
module sha_round
    import sha_pkg::*;
(
    input  logic [255:0] v_in,
    input  logic [31:0]  w_t,
    input  logic [31:0]  k_t,
    input  logic [31:0]  w1,
    input  logic [31:0]  w9,
    input  logic [31:0]  w14,
    input  logic [31:0]  w0,
    output logic [255:0] v_out,
    output logic [31:0]  w_new
);
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;

    always_comb begin
        {a, b, c, d, e, f, g, h} = v_in;
        t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
           + ((e & f) ^ (~e & g)) + k_t + w_t;
        t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
           + ((a & b) ^ (a & c) ^ (b & c));
        v_out = {t1 + t2, a, b, c, d + t1, e, f, g};
        s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
        s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ {10'd0, w14[31:10]};
        w_new = w0 + s0 + w9 + s1;
    end
endmodule

### hw/rtl/sha256_message_digest.sv
// A byte-mode data word is accepted and then inserted bit by bit, MSB first; a bit-mode word inserts one bit.
// A word whose bit fills the 512-bit block then runs the rounds (ST_ROUND) and the add-back (ST_ADD).
// A last word then inserts the padding one, the zeros and the 64-bit length, compressing each block that fills,
// then outputs 8 digest words at one per cycle while m_ready is high, and ST_OUT reinitializes the hash.
// Throughput: one word at a time; s_ready is low while the sequencer runs or a result waits.
// Reset (aresetn low, synchronous): initial hash, empty block, zero length, mode 0.
`include "sha256_message_digest_defines.svh"
module sha256_message_digest
    import sha_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cfg_wr_en,
    input  logic     cfg_wr_data,
    input  logic     s_valid,
    output logic     s_ready,
    input  sha_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sha_out_t m_data
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_BITS  = 7'b0000010,
        ST_ROUND = 7'b0000100,
        ST_ADD   = 7'b0001000,
        ST_PAD   = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_ERR   = 7'b1000000
    } state_t;

    // pad phases
    typedef enum logic [1:0] {PH_DATA, PH_ONE, PH_ZERO, PH_LEN} phase_t;

    state_t        state_reg;
    phase_t        phase_reg;
    logic          mode_reg;
    logic          aborted_reg;
    logic          last_reg;
    logic [7:0]    byte_reg;
    logic [2:0]    bcnt_reg;
    logic [5:0]    lcnt_reg;
    logic [8:0]    fill_reg;
    logic [63:0]   len_reg;
    logic [31:0]   hash_reg [8];
    logic [255:0]  v_reg;
    logic [31:0]   w_reg [16];
    logic [5:0]    rnd_reg;
    logic [2:0]    oidx_reg;
    logic          m_valid_reg;
    sha_out_t      m_data_reg;
    // word finished / length finished when the block filled
    logic          done_byte_reg;
    logic          done_len_reg;

    logic [255:0]  v_next;
    logic [31:0]   w_next;
    logic          cur_bit;
    logic [3:0]    widx;
    logic [4:0]    bidx;
    logic          accept;
    logic          load_out;

    assign s_ready  = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign widx     = fill_reg[8:5];
    assign bidx     = 5'd31 - fill_reg[4:0];
    assign load_out = (state_reg == ST_PAD || state_reg == ST_ERR) &&
                      (!m_valid_reg || m_ready);

    sha_round u_round (
        .v_in(v_reg), .w_t(w_reg[0]), .k_t(ROUND_K[rnd_reg]),
        .w1(w_reg[1]), .w9(w_reg[9]), .w14(w_reg[14]), .w0(w_reg[0]),
        .v_out(v_next), .w_new(w_next)
    );

    // bit source for the insert port
    always_comb begin
        case (phase_reg)
            PH_DATA: cur_bit = byte_reg[bcnt_reg];
            PH_ONE:  cur_bit = 1'b1;
            PH_ZERO: cur_bit = 1'b0;
            default: cur_bit = len_reg[lcnt_reg];
        endcase
    end

    // block store, one bit written per cycle while in ST_BITS, shifted during rounds
    always_ff @(posedge aclk) begin
        if (state_reg == ST_BITS) begin
            w_reg[widx][bidx] <= cur_bit;
        end else if (state_reg == ST_ROUND) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_DATA;
            mode_reg    <= 1'b0;
            aborted_reg <= 1'b0;
            last_reg    <= 1'b0;
            fill_reg    <= '0;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
            rnd_reg     <= '0;
            oidx_reg    <= '0;
            bcnt_reg    <= '0;
            lcnt_reg    <= '0;
            for (int i = 0; i < 8; i++) hash_reg[i] <= init_h(3'(i));
        end else begin
            if (cfg_wr_en) mode_reg <= cfg_wr_data;
            if (m_valid_reg && m_ready && !load_out) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        byte_reg  <= s_data.data_byte;
                        last_reg  <= s_data.last;
                        phase_reg <= PH_DATA;
                        if (aborted_reg) begin
                            if (s_data.last) begin
                                aborted_reg <= 1'b0;
                                fill_reg    <= '0;
                                len_reg     <= '0;
                                for (int i = 0; i < 8; i++) hash_reg[i] <= init_h(3'(i));
                            end
                        end else if (s_data.has_data) begin
                            if (!mode_reg) begin
                                bcnt_reg  <= 3'd7;
                                len_reg   <= len_reg + 64'd8;
                                state_reg <= ST_BITS;
                            end else if (s_data.data_byte == CHAR_ZERO ||
                                         s_data.data_byte == CHAR_ONE) begin
                                bcnt_reg  <= 3'd0;
                                len_reg   <= len_reg + 64'd1;
                                state_reg <= ST_BITS;
                            end else begin
                                state_reg <= ST_ERR;
                            end
                        end else if (s_data.last) begin
                            phase_reg <= PH_ONE;
                            state_reg <= ST_BITS;
                        end
                    end
                end
                ST_BITS: begin
                    fill_reg      <= fill_reg + 9'd1;
                    done_byte_reg <= (phase_reg == PH_DATA && bcnt_reg == 3'd0 && !last_reg);
                    done_len_reg  <= (phase_reg == PH_LEN && lcnt_reg == 6'd0);
                    // advance the bit source
                    case (phase_reg)
                        PH_DATA: begin
                            if (bcnt_reg != 3'd0) bcnt_reg <= bcnt_reg - 3'd1;
                            else if (last_reg) phase_reg <= PH_ONE;
                            else phase_reg <= PH_DATA;
                        end
                        PH_ONE: phase_reg <= (fill_reg + 9'd1 == PAD_FILL) ? PH_LEN : PH_ZERO;
                        PH_ZERO: if (fill_reg + 9'd1 == PAD_FILL) phase_reg <= PH_LEN;
                        default: lcnt_reg <= lcnt_reg - 6'd1;
                    endcase
                    if (phase_reg == PH_ONE || (phase_reg == PH_ZERO &&
                        fill_reg + 9'd1 == PAD_FILL)) lcnt_reg <= 6'd63;
                    if (fill_reg == 9'd511) begin
                        state_reg <= ST_ROUND;
                        rnd_reg   <= '0;
                        v_reg     <= {hash_reg[0], hash_reg[1], hash_reg[2], hash_reg[3],
                                      hash_reg[4], hash_reg[5], hash_reg[6], hash_reg[7]};
                    end else if (phase_reg == PH_DATA && bcnt_reg == 3'd0 && !last_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ROUND: begin
                    v_reg   <= v_next;
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63) state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_reg[i] + v_reg[255 - 32*i -: 32];
                    fill_reg <= '0;
                    // length finished means the digest is ready
                    if (done_len_reg) begin
                        state_reg <= ST_PAD;
                        oidx_reg  <= '0;
                    end else if (done_byte_reg) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_BITS;
                    end
                end
                ST_PAD: begin
                    if (load_out) begin
                        m_valid_reg            <= 1'b1;
                        m_data_reg.digest_word <= hash_reg[oidx_reg];
                        m_data_reg.word_index  <= oidx_reg;
                        m_data_reg.error       <= 1'b0;
                        m_data_reg.last_word   <= (oidx_reg == 3'd7);
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7) state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    fill_reg  <= '0;
                    len_reg   <= '0;
                    phase_reg <= PH_DATA;
                    for (int i = 0; i < 8; i++) hash_reg[i] <= init_h(3'(i));
                    state_reg <= ST_IDLE;
                end
                ST_ERR: begin
                    if (load_out) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= '{digest_word: '0, word_index: '0,
                                         error: 1'b1, last_word: 1'b1};
                        if (last_reg) begin
                            fill_reg <= '0;
                            len_reg  <= '0;
                            for (int i = 0; i < 8; i++) hash_reg[i] <= init_h(3'(i));
                        end else begin
                            aborted_reg <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `SHA_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready, state_reg == ST_IDLE)
    `SHA_ASSERT_NXT(a_round_cnt, aclk, aresetn, state_reg == ST_ROUND && rnd_reg != 6'd63,
                    state_reg == ST_ROUND)
    `SHA_ASSERT_IMP(a_err_last, aclk, aresetn, m_valid_reg && m_data_reg.error,
                    m_data_reg.last_word)
endmodule
